[sv/sci_pkg.sv]
// Shared register index codes for the segment and circle intersection core.
`default_nettype none
package sci_pkg;

  localparam int CfgIndexWidth = 2;

  typedef logic [CfgIndexWidth-1:0] cfg_index_t;

  localparam cfg_index_t CFG_CENTER_X  = 2'd0;
  localparam cfg_index_t CFG_CENTER_Y  = 2'd1;
  localparam cfg_index_t CFG_RADIUS_SQ = 2'd2;

endpackage
`default_nettype wire

[sv/segment_circle_intersection_core.sv]
// Pipelined intersection of a line segment with a configured circle.
//
// Usage: the circle center (center_x, center_y, signed) and the squared
// radius (radius_sq, unsigned, twice the coordinate width) are written through
// the cfg_write / cfg_index / cfg_data port while no item is in flight.
// Segments enter on the input channel (in_valid, in_stall) and one result item
// per segment leaves on the output channel (out_valid, out_stall). A result
// carries both points where the line meets the circle, each with a flag that
// tells whether it lies in the segment's bounding box.
//
// The pipeline computes the partial products, their sums and the discriminant,
// then the square root, one root bit per step (2*COORD_WIDTH + 1 bits),
// then the root products and the numerators, then the four dividers, one
// quotient bit per step (COORD_WIDTH + 2 bits), and ends in the output
// register. A new item is accepted in every cycle; the whole pipeline
// advances as one and stalls only while a finished result sits in the output
// register and the receiver stalls it.
// Reset clears every valid bit and the configuration registers to zero; items
// in flight are dropped.
`default_nettype none
module segment_circle_intersection_core #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  sci_pkg::cfg_index_t           cfg_index,
  input  logic [2*COORD_WIDTH-1:0]      cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] first_x,
  output logic signed [COORD_WIDTH-1:0] first_y,
  output logic signed [COORD_WIDTH-1:0] second_x,
  output logic signed [COORD_WIDTH-1:0] second_y,
  output logic                          first_valid,
  output logic                          second_valid
);
  import sci_pkg::*;

  localparam int C    = COORD_WIDTH;
  localparam int HB   = C + 1;    // split point of the wide multiplier operands
  localparam int LW   = 2*C + 2;  // squared length
  localparam int KW   = 2*C + 3;  // cross product k
  localparam int PW   = 3*C + 4;  // direction times k
  localparam int DW   = 4*C + 2;  // nonnegative discriminant
  localparam int RW   = 2*C + 1;  // its square root
  localparam int NUMW = 3*C + 5;  // signed numerators
  localparam int NW   = 3*C + 7;  // divider remainder
  localparam int QB   = C + 2;    // quotient bits before overflow
  localparam int XW   = C + 4;    // unsaturated coordinate

  localparam logic signed [XW-1:0] PMAX = {{5{1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [XW-1:0] PMIN = {{5{1'b1}}, {(C-1){1'b0}}};

  typedef struct packed {
    logic signed [C-1:0]  sx;
    logic signed [C-1:0]  sy;
    logic signed [C-1:0]  ex;
    logic signed [C-1:0]  ey;
    logic signed [C:0]    dx;
    logic signed [C:0]    dy;
    logic [LW-1:0]        l2;
    logic signed [PW-1:0] fxn;
    logic signed [PW-1:0] dxk;
    logic                 nul;
  } car_t;

  typedef struct packed {
    car_t          c;
    logic [DW-1:0] rem;
    logic [RW-1:0] root;
  } sq_t;

  typedef struct packed {
    logic signed [C-1:0]    sx;
    logic signed [C-1:0]    sy;
    logic signed [C-1:0]    ex;
    logic signed [C-1:0]    ey;
    logic                   dxneg;
    logic                   nul;
    logic [NW-1:0]          d;
    logic [3:0][NW-1:0]     rem;
    logic [3:0][QB-1:0]     q;
    logic [3:0]             neg;
    logic [3:0]             ovf;
  } dv_t;

  // Configuration registers.
  logic signed [C-1:0] cx;
  logic signed [C-1:0] cy;
  logic [2*C-1:0]      r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      cx <= '0;
      cy <= '0;
      r2 <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CENTER_X:  cx <= cfg_data[C-1:0];
        CFG_CENTER_Y:  cy <= cfg_data[C-1:0];
        CFG_RADIUS_SQ: r2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves as a whole whenever the output register can take a result.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage 1: direction and offset from the center.
  logic                v1;
  logic signed [C-1:0] sx1, sy1, ex1, ey1;
  logic signed [C:0]   dx1, dy1, fx1, fy1;

  // Stage 2: products of the direction.
  logic                  v2;
  logic signed [C-1:0]   sx2, sy2, ex2, ey2;
  logic signed [C:0]     dx2, dy2;
  logic signed [2*C+1:0] dxx2, dyy2, pa2, pb2;

  // Stage 3: squared length and cross product.
  logic                 v3;
  logic signed [C-1:0]  sx3, sy3, ex3, ey3;
  logic signed [C:0]    dx3, dy3;
  logic [LW-1:0]        l23;
  logic signed [KW-1:0] k3;

  // Stage 4: partial products. The wide operands are cut at bit HB so that
  // every multiplier stays about as wide as a coordinate.
  logic                  v4;
  logic signed [C-1:0]   sx4, sy4, ex4, ey4;
  logic signed [C:0]     dx4, dy4;
  logic [LW-1:0]         l24;
  logic [2*C:0]          lrhh4, lrhl4, lrlh4, lrll4;
  logic signed [2*C+3:0] kkhh4, kkhl4;
  logic [2*C+1:0]        kkll4;
  logic signed [2*C+2:0] dykh4, dykl4, dxkh4, dxkl4;

  // Stage 5: the partial products summed into L2*r2, k*k, dy*k and dx*k.
  logic                   v5;
  logic signed [C-1:0]    sx5, sy5, ex5, ey5;
  logic signed [C:0]      dx5, dy5;
  logic [LW-1:0]          l25;
  logic [DW-1:0]          a5;
  logic signed [2*KW-1:0] kk5;
  logic signed [PW-1:0]   fxn5, dxk5;

  always_ff @(posedge clk) begin
    if (adv) begin
      sx1 <= start_x;
      sy1 <= start_y;
      ex1 <= end_x;
      ey1 <= end_y;
      dx1 <= $signed({end_x[C-1], end_x}) - $signed({start_x[C-1], start_x});
      dy1 <= $signed({end_y[C-1], end_y}) - $signed({start_y[C-1], start_y});
      fx1 <= $signed({start_x[C-1], start_x}) - $signed({cx[C-1], cx});
      fy1 <= $signed({start_y[C-1], start_y}) - $signed({cy[C-1], cy});

      {sx2, sy2, ex2, ey2} <= {sx1, sy1, ex1, ey1};
      dx2  <= dx1;
      dy2  <= dy1;
      dxx2 <= dx1 * dx1;
      dyy2 <= dy1 * dy1;
      pa2  <= dy1 * fx1;
      pb2  <= dx1 * fy1;

      {sx3, sy3, ex3, ey3} <= {sx2, sy2, ex2, ey2};
      dx3 <= dx2;
      dy3 <= dy2;
      l23 <= $unsigned(dxx2) + $unsigned(dyy2);
      k3  <= KW'(pa2) - KW'(pb2);

      {sx4, sy4, ex4, ey4} <= {sx3, sy3, ex3, ey3};
      dx4   <= dx3;
      dy4   <= dy3;
      l24   <= l23;
      lrhh4 <= l23[LW-1:HB] * r2[2*C-1:C];
      lrhl4 <= l23[LW-1:HB] * r2[C-1:0];
      lrlh4 <= l23[HB-1:0] * r2[2*C-1:C];
      lrll4 <= l23[HB-1:0] * r2[C-1:0];
      kkhh4 <= $signed(k3[KW-1:HB]) * $signed(k3[KW-1:HB]);
      kkhl4 <= $signed(k3[KW-1:HB]) * $signed({1'b0, k3[HB-1:0]});
      kkll4 <= k3[HB-1:0] * k3[HB-1:0];
      dykh4 <= dy3 * $signed(k3[KW-1:HB]);
      dykl4 <= dy3 * $signed({1'b0, k3[HB-1:0]});
      dxkh4 <= dx3 * $signed(k3[KW-1:HB]);
      dxkl4 <= dx3 * $signed({1'b0, k3[HB-1:0]});

      {sx5, sy5, ex5, ey5} <= {sx4, sy4, ex4, ey4};
      dx5  <= dx4;
      dy5  <= dy4;
      l25  <= l24;
      a5   <= ((DW'(lrhh4) << (2*C+1)) + (DW'(lrhl4) << HB))
            + ((DW'(lrlh4) << C) + DW'(lrll4));
      kk5  <= ((2*KW)'(kkhh4) << (2*HB))
            + (((2*KW)'(kkhl4) << (HB+1)) + (2*KW)'(kkll4));
      fxn5 <= (PW'(dykh4) << HB) + PW'(dykl4);
      dxk5 <= (PW'(dxkh4) << HB) + PW'(dxkl4);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Stage 6: discriminant. A line that misses the circle or a point segment runs
  // through the rest of the pipeline marked null and comes out as all zeros.
  logic signed [DW+4:0] dsc6;
  assign dsc6 = $signed({5'b0, a5}) - $signed({kk5[2*KW-1], kk5});

  sq_t  sq  [RW+1];
  logic sqv [RW+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq[0].c.sx   <= sx5;
      sq[0].c.sy   <= sy5;
      sq[0].c.ex   <= ex5;
      sq[0].c.ey   <= ey5;
      sq[0].c.dx   <= dx5;
      sq[0].c.dy   <= dy5;
      sq[0].c.l2   <= l25;
      sq[0].c.fxn  <= fxn5;
      sq[0].c.dxk  <= dxk5;
      sq[0].c.nul  <= (l25 == '0) || dsc6[DW+4];
      sq[0].rem    <= dsc6[DW+4] ? '0 : dsc6[DW-1:0];
      sq[0].root   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sqv[0] <= 1'b0;
    end else if (adv) begin
      sqv[0] <= v5;
    end
  end

  // Square root, one result bit per stage from the top down.
  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    localparam int B = RW - 1 - i;
    logic [DW-1:0] t;
    sq_t           sq_next;
    assign t = (DW'(sq[i].root) << (B + 1)) | (DW'(1) << (2 * B));

    always_comb begin
      sq_next = sq[i];
      if (t <= sq[i].rem) begin
        sq_next.rem  = sq[i].rem - t;
        sq_next.root = sq[i].root | (RW'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq[i+1] <= sq_next;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sqv[i+1] <= 1'b0;
      end else if (adv) begin
        sqv[i+1] <= sqv[i];
      end
    end
  end

  // Stage 7: direction times the two halves of the root.
  logic                  v7;
  car_t                  c7;
  logic signed [2*C+2:0] dxrl7, dxrh7, dyrl7, dyrh7;

  // Stage 8: direction times the root.
  logic                 v8;
  car_t                 c8;
  logic signed [PW-2:0] dxh8, dyh8;

  // Stage 9: numerators of the four coordinates, forward x, forward y,
  // backward x, backward y.
  logic                     v9;
  car_t                     c9;
  logic [3:0][NUMW-1:0]     n9;

  always_ff @(posedge clk) begin
    if (adv) begin
      c7    <= sq[RW].c;
      dxrl7 <= sq[RW].c.dx * $signed({1'b0, sq[RW].root[HB-1:0]});
      dxrh7 <= sq[RW].c.dx * $signed({1'b0, sq[RW].root[RW-1:HB]});
      dyrl7 <= sq[RW].c.dy * $signed({1'b0, sq[RW].root[HB-1:0]});
      dyrh7 <= sq[RW].c.dy * $signed({1'b0, sq[RW].root[RW-1:HB]});

      c8   <= c7;
      dxh8 <= ((PW-1)'(dxrh7) << HB) + (PW-1)'(dxrl7);
      dyh8 <= ((PW-1)'(dyrh7) << HB) + (PW-1)'(dyrl7);

      c9    <= c8;
      n9[0] <= NUMW'(c8.fxn) + NUMW'(dxh8);
      n9[1] <= NUMW'(dyh8) - NUMW'(c8.dxk);
      n9[2] <= NUMW'(c8.fxn) - NUMW'(dxh8);
      n9[3] <= -NUMW'(c8.dxk) - NUMW'(dyh8);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else if (adv) begin
      v7 <= sqv[RW];
      v8 <= v7;
      v9 <= v8;
    end
  end

  // Stage 10: rounding to nearest becomes floor((2|n| + L2) / (2 L2)).
  // Quotients that would need more than QB bits lie far outside the
  // coordinate range and are only flagged.
  dv_t  dv  [QB+1];
  logic dvv [QB+1];

  logic [NW-1:0]       d10;
  logic [3:0][NW-1:0]  num10;
  logic [3:0]          neg10;

  assign d10 = NW'(c9.l2) << 1;

  for (genvar g = 0; g < 4; g++) begin : g_num
    logic [NUMW-1:0] mag;
    assign neg10[g] = n9[g][NUMW-1];
    assign mag      = neg10[g] ? -n9[g] : n9[g];
    assign num10[g] = (NW'(mag) << 1) + NW'(c9.l2);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0].sx    <= c9.sx;
      dv[0].sy    <= c9.sy;
      dv[0].ex    <= c9.ex;
      dv[0].ey    <= c9.ey;
      dv[0].dxneg <= c9.dx[C];
      dv[0].nul   <= c9.nul;
      dv[0].d     <= d10;
      dv[0].rem   <= num10;
      dv[0].q     <= '0;
      dv[0].neg   <= neg10;
      for (int l = 0; l < 4; l++) begin
        dv[0].ovf[l] <= num10[l] >= (d10 << QB);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else if (adv) begin
      dvv[0] <= v9;
    end
  end

  // Four restoring dividers side by side, one quotient bit per stage.
  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int B = QB - 1 - j;
    logic [NW-1:0] dsh;
    dv_t           dv_next;
    assign dsh = dv[j].d << B;

    always_comb begin
      dv_next = dv[j];
      for (int l = 0; l < 4; l++) begin
        if (dv[j].rem[l] >= dsh) begin
          dv_next.rem[l]  = dv[j].rem[l] - dsh;
          dv_next.q[l][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv[j+1] <= dv_next;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[j+1] <= 1'b0;
      end else if (adv) begin
        dvv[j+1] <= dvv[j];
      end
    end
  end

  // Final: add the center, judge the bounding box, saturate, order.
  dv_t                 fin;
  logic [3:0]          inb;
  logic [3:0][C-1:0]   sat;
  logic signed [C-1:0] xmin, xmax, ymin, ymax;

  assign fin  = dv[QB];
  assign xmin = (fin.sx < fin.ex) ? fin.sx : fin.ex;
  assign xmax = (fin.sx < fin.ex) ? fin.ex : fin.sx;
  assign ymin = (fin.sy < fin.ey) ? fin.sy : fin.ey;
  assign ymax = (fin.sy < fin.ey) ? fin.ey : fin.sy;

  for (genvar g = 0; g < 4; g++) begin : g_lane
    localparam bit IsY = (g % 2) == 1;
    logic signed [QB:0]   qs;
    logic signed [XW-1:0] pv;
    logic signed [C-1:0]  lo, hi, cc;

    assign qs = fin.neg[g] ? -$signed({1'b0, fin.q[g]}) : $signed({1'b0, fin.q[g]});
    assign cc = IsY ? cy : cx;
    assign lo = IsY ? ymin : xmin;
    assign hi = IsY ? ymax : xmax;
    assign pv = XW'(cc) + XW'(qs);

    assign inb[g] = !fin.ovf[g] && (lo <= pv) && (pv <= hi);

    always_comb begin
      if (fin.ovf[g]) begin
        sat[g] = fin.neg[g] ? PMIN[C-1:0] : PMAX[C-1:0];
      end else if (pv > PMAX) begin
        sat[g] = PMAX[C-1:0];
      end else if (pv < PMIN) begin
        sat[g] = PMIN[C-1:0];
      end else begin
        sat[g] = pv[C-1:0];
      end
    end
  end

  logic fwv, bkv, swap;
  assign fwv  = inb[0] && inb[1];
  assign bkv  = inb[2] && inb[3];
  assign swap = (fwv && bkv) || fin.dxneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dvv[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (fin.nul) begin
        first_x      <= '0;
        first_y      <= '0;
        second_x     <= '0;
        second_y     <= '0;
        first_valid  <= 1'b0;
        second_valid <= 1'b0;
      end else if (swap) begin
        first_x      <= sat[2];
        first_y      <= sat[3];
        second_x     <= sat[0];
        second_y     <= sat[1];
        first_valid  <= bkv;
        second_valid <= fwv;
      end else begin
        first_x      <= sat[0];
        first_y      <= sat[1];
        second_x     <= sat[2];
        second_y     <= sat[3];
        first_valid  <= fwv;
        second_valid <= bkv;
      end
    end
  end

endmodule
`default_nettype wire
